FILE: rtl/aqc_pkg.sv
// ----------------------------------------------------------------------------
// aqc_pkg
// shared types, constants and lookup functions of the autotile quadrant composer
// ----------------------------------------------------------------------------
package aqc_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_KINDS   = 16;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int KIND_W      = 4;
    localparam int ENTRY_W     = KIND_W + 1;
    localparam int NUM_READS   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 2'd3;

    localparam logic [3:0] FILLER_CELL = 4'd3;

    typedef struct packed {
        logic              opcode;
        logic [COL_W-1:0]  cell_x;
        logic [ROW_W-1:0]  cell_y;
        logic              cell_present;
        logic [KIND_W-1:0] kind_index;
        logic [3:0]        frame;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctrl;

    // base pattern keyed by the orthogonal bits, one entry per quadrant
    localparam logic [3:0] BASE_TABLE [16][4] = '{
        '{4'd1,  4'd1,  4'd1,  4'd1},  '{4'd10, 4'd12, 4'd10, 4'd12},
        '{4'd4,  4'd4,  4'd10, 4'd10}, '{4'd10, 4'd10, 4'd10, 4'd10},
        '{4'd4,  4'd6,  4'd4,  4'd6},  '{4'd7,  4'd9,  4'd7,  4'd9},
        '{4'd4,  4'd4,  4'd4,  4'd4},  '{4'd7,  4'd7,  4'd7,  4'd7},
        '{4'd6,  4'd6,  4'd12, 4'd12}, '{4'd12, 4'd12, 4'd12, 4'd12},
        '{4'd5,  4'd5,  4'd11, 4'd11}, '{4'd11, 4'd11, 4'd11, 4'd11},
        '{4'd6,  4'd6,  4'd6,  4'd6},  '{4'd9,  4'd9,  4'd9,  4'd9},
        '{4'd5,  4'd5,  4'd5,  4'd5},  '{4'd8,  4'd8,  4'd8,  4'd8}
    };

    // mini-pattern cell of one quadrant, with the inner-corner override
    function automatic logic [3:0] f_pattern(input logic [7:0] mask, input logic [1:0] q);
        logic o1, o2, d;
        case (q)
            2'd0: begin
                o1 = mask[0]; o2 = mask[3]; d = mask[4];
            end
            2'd1: begin
                o1 = mask[0]; o2 = mask[1]; d = mask[5];
            end
            2'd2: begin
                o1 = mask[2]; o2 = mask[3]; d = mask[7];
            end
            default: begin
                o1 = mask[2]; o2 = mask[1]; d = mask[6];
            end
        endcase
        if (o1 && o2 && !d) begin
            return FILLER_CELL;
        end
        return BASE_TABLE[mask[3:0]][q];
    endfunction

    // {row, col} of a one-based pattern cell in the 3-wide sheet
    function automatic logic [3:0] f_cell_pos(input logic [3:0] pat);
        case (pat)
            4'd1:    return {2'd0, 2'd0};
            4'd2:    return {2'd0, 2'd1};
            4'd3:    return {2'd0, 2'd2};
            4'd4:    return {2'd1, 2'd0};
            4'd5:    return {2'd1, 2'd1};
            4'd6:    return {2'd1, 2'd2};
            4'd7:    return {2'd2, 2'd0};
            4'd8:    return {2'd2, 2'd1};
            4'd9:    return {2'd2, 2'd2};
            4'd10:   return {2'd3, 2'd0};
            4'd11:   return {2'd3, 2'd1};
            4'd12:   return {2'd3, 2'd2};
            default: return 4'd0;
        endcase
    endfunction

    // neighbour offsets: self, top, right, bottom, left, tl, tr, br, bl
    function automatic logic [7:0] f_dx(input logic [3:0] n);
        case (n)
            4'd2, 4'd6, 4'd7: return 8'h01;
            4'd4, 4'd5, 4'd8: return 8'hFF;
            default:          return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] f_dy(input logic [3:0] n);
        case (n)
            4'd1, 4'd5, 4'd6: return 8'hFF;
            4'd3, 4'd7, 4'd8: return 8'h01;
            default:          return 8'h00;
        endcase
    endfunction

endpackage

FILE: rtl/aqc_front.sv
// ----------------------------------------------------------------------------
// aqc_front
// command intake: takes items and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module aqc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  aqc_pkg::t_item      i_item,
    input  aqc_pkg::t_back_ctrl i_ctrl,
    output aqc_pkg::t_head      o_head
);

    aqc_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign busy = (r_cnt == 2'd2) || i_ctrl.clearing;
    assign push = start && !busy;
    assign pop  = i_ctrl.pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/aqc_back.sv
// ----------------------------------------------------------------------------
// aqc_back
// cell store, neighbour read sequencer and quadrant result generation
// ----------------------------------------------------------------------------
module aqc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aqc_pkg::t_head                      i_head,
    input  logic [aqc_pkg::CFG_DATA_W-1:0]      i_map_width,
    input  logic [aqc_pkg::CFG_DATA_W-1:0]      i_map_height,
    input  logic [aqc_pkg::CFG_DATA_W-1:0]      i_tile_size,
    input  logic [4:0]                          i_pool_count,
    output aqc_pkg::t_back_ctrl                 o_ctrl,
    output logic                                o_valid,
    output logic                                o_drawn,
    output logic [1:0]                          o_quadrant,
    output logic [3:0]                          o_pattern_cell,
    output logic [7:0]                          o_neighbour_mask,
    output logic [11:0]                         o_src_x,
    output logic [7:0]                          o_src_y,
    output logic [11:0]                         o_dest_x,
    output logic [11:0]                         o_dest_y,
    output logic                                o_last
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam int AW = aqc_pkg::ADDR_W;
    localparam int EW = aqc_pkg::ENTRY_W;
    localparam int KW = aqc_pkg::KIND_W;
    localparam logic [3:0] LAST_STEP = 4'(aqc_pkg::NUM_READS);

    logic [EW-1:0] r_mem [aqc_pkg::STORE_DEPTH];

    logic [1:0]     r_state;
    logic [AW-1:0]  r_clr;
    logic [3:0]     r_step;
    logic [1:0]     r_q;
    aqc_pkg::t_item r_item;
    logic [KW-1:0]  r_self_kind;
    logic           r_self_ok;
    logic [7:0]     r_mask;
    logic [11:0]    r_fx;
    logic [11:0]    r_dx;
    logic [11:0]    r_dy;
    logic [EW-1:0]  r_rd_data;
    logic           r_rd_in;
    logic [3:0]     r_rd_idx;

    logic [aqc_pkg::CFG_DATA_W-1:0] eff_w;
    logic [aqc_pkg::CFG_DATA_W-1:0] eff_h;
    logic [7:0]     nx;
    logic [7:0]     ny;
    logic           rd_in;
    logic [AW-1:0]  rd_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [EW-1:0]  mem_wdata;
    logic           take;
    logic           match;
    logic [5:0]     half;
    logic [3:0]     pat;
    logic [3:0]     pos;
    logic [7:0]     col_ts;
    logic [8:0]     row_ts;
    logic [5:0]     qx_half;
    logic [5:0]     qy_half;
    logic [12:0]    fx_prod;
    logic [12:0]    dx_prod;
    logic [12:0]    dy_prod;

    assign eff_w = (i_map_width > 7'(aqc_pkg::MAX_COLUMNS)) ? 7'(aqc_pkg::MAX_COLUMNS)
                                                            : i_map_width;
    assign eff_h = (i_map_height > 7'(aqc_pkg::MAX_ROWS)) ? 7'(aqc_pkg::MAX_ROWS)
                                                          : i_map_height;

    // neighbour address, -1 wraps high and falls outside the map
    assign nx      = {2'b00, r_item.cell_x} + aqc_pkg::f_dx(r_step);
    assign ny      = {2'b00, r_item.cell_y} + aqc_pkg::f_dy(r_step);
    assign rd_in   = (nx < {1'b0, eff_w}) && (ny < {1'b0, eff_h});
    assign rd_addr = {ny[aqc_pkg::ROW_W-1:0], nx[aqc_pkg::COL_W-1:0]};

    assign take = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {i_head.item.cell_y, i_head.item.cell_x};
        mem_wdata = i_head.item.cell_present ? {1'b1, i_head.item.kind_index} : '0;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (take && (i_head.item.opcode == aqc_pkg::OP_WRITE)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_ctrl.pop      = take;
    assign o_ctrl.clearing = (r_state == S_CLEAR);

    assign match = r_rd_in && r_rd_data[EW-1] && (r_rd_data[KW-1:0] == r_self_kind);

    assign half    = i_tile_size[6:1];
    assign pat     = aqc_pkg::f_pattern(r_mask, r_q);
    assign pos     = aqc_pkg::f_cell_pos(pat);
    assign col_ts  = (pos[1:0] == 2'd2) ? {i_tile_size, 1'b0} :
                     (pos[1:0] == 2'd1) ? {1'b0, i_tile_size} : 8'd0;
    assign row_ts  = 9'(pos[3:2]) * 9'(i_tile_size);
    assign qx_half = r_q[0] ? half : 6'd0;
    assign qy_half = r_q[1] ? half : 6'd0;

    assign fx_prod = 13'(i_head.item.frame) * 13'd3 * 13'(i_tile_size);
    assign dx_prod = 13'(i_head.item.cell_x) * 13'(i_tile_size);
    assign dy_prod = 13'(i_head.item.cell_y) * 13'(i_tile_size);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_step  <= 4'd0;
            r_q     <= 2'd0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + {{(AW-1){1'b0}}, 1'b1};
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take && (i_head.item.opcode == aqc_pkg::OP_QUERY)) begin
                        r_state <= S_READ;
                        r_step  <= 4'd0;
                    end
                end
                S_READ: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_EMIT;
                        r_q     <= 2'd0;
                    end
                end
                S_EMIT: begin
                    o_valid <= 1'b1;
                    r_q     <= r_q + 2'd1;
                    if (!r_self_ok || (r_q == 2'd3)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_in  <= rd_in;
        r_rd_idx <= r_step;
        if (take) begin
            r_item <= i_head.item;
            r_fx   <= fx_prod[11:0];
            r_dx   <= dx_prod[11:0];
            r_dy   <= dy_prod[11:0];
            r_mask <= 8'd0;
        end
        if ((r_state == S_READ) && (r_step != 4'd0)) begin
            if (r_rd_idx == 4'd0) begin
                r_self_kind <= r_rd_data[KW-1:0];
                r_self_ok   <= r_rd_in && r_rd_data[EW-1]
                               && ({1'b0, r_rd_data[KW-1:0]} < i_pool_count);
            end else begin
                r_mask[3'(r_rd_idx - 4'd1)] <= match;
            end
        end
        if (r_state == S_EMIT) begin
            if (!r_self_ok) begin
                o_drawn          <= 1'b0;
                o_quadrant       <= 2'd0;
                o_pattern_cell   <= 4'd0;
                o_neighbour_mask <= 8'd0;
                o_src_x          <= 12'd0;
                o_src_y          <= 8'd0;
                o_dest_x         <= 12'd0;
                o_dest_y         <= 12'd0;
                o_last           <= 1'b1;
            end else begin
                o_drawn          <= 1'b1;
                o_quadrant       <= r_q;
                o_pattern_cell   <= pat;
                o_neighbour_mask <= r_mask;
                o_src_x          <= r_fx + {4'd0, col_ts} + {6'd0, qx_half};
                o_src_y          <= row_ts[7:0] + {2'b00, qy_half};
                o_dest_x         <= r_dx + {6'd0, qx_half};
                o_dest_y         <= r_dy + {6'd0, qy_half};
                o_last           <= (r_q == 2'd3);
            end
        end
    end

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid)
        else $error("result during store clear");

    a_undrawn_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_drawn) |-> o_last)
        else $error("undrawn result not marked last");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result straight after last");

    a_quadrant_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && (o_quadrant == 2'($past(o_quadrant) + 2'd1))))
        else $error("quadrant sequence broken");

endmodule

FILE: rtl/autotile_quadrant_composer.sv
// ----------------------------------------------------------------------------
// autotile_quadrant_composer
// autotile grid store with neighbour-mask queries and per-quadrant blit coordinates
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// command   in         start, busy               i_opcode .. i_frame
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
// result    out        o_valid (strobe)          o_drawn .. o_last
//
// a write is stored as the back end takes it from the queue; a query leaves the
// queue, then reads nine entries through the single store read port, one per
// cycle, plus a last step for the registered read data, and gives 4 result
// beats (1 when not drawn)
// after reset the store is cleared one entry a cycle, all 4096 entries, with busy high
// a two-entry queue sits between intake and back end; busy rises when it is full
// result beats are strobed for one cycle each; the receiver cannot stall
// config writes are always taken (ready tied high)
//
module autotile_quadrant_composer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic [5:0]                          i_cell_x,
    input  logic [5:0]                          i_cell_y,
    input  logic                                i_cell_present,
    input  logic [3:0]                          i_kind_index,
    input  logic [3:0]                          i_frame,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aqc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [aqc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // result
    output logic                                o_valid,
    output logic                                o_drawn,
    output logic [1:0]                          o_quadrant,
    output logic [3:0]                          o_pattern_cell,
    output logic [7:0]                          o_neighbour_mask,
    output logic [11:0]                         o_src_x,
    output logic [7:0]                          o_src_y,
    output logic [11:0]                         o_dest_x,
    output logic [11:0]                         o_dest_y,
    output logic                                o_last
);

    // configuration registers
    logic [aqc_pkg::CFG_DATA_W-1:0] r_map_width;
    logic [aqc_pkg::CFG_DATA_W-1:0] r_map_height;
    logic [aqc_pkg::CFG_DATA_W-1:0] r_tile_size;
    logic [4:0]                     r_pool_count;

    aqc_pkg::t_item      cmd_item;
    aqc_pkg::t_head      head;
    aqc_pkg::t_back_ctrl back_ctrl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 7'd64;
            r_map_height <= 7'd64;
            r_tile_size  <= 7'd32;
            r_pool_count <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                aqc_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                aqc_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                aqc_pkg::CFG_TILE_SIZE:  r_tile_size  <= i_cfg_data;
                aqc_pkg::CFG_POOL_COUNT: r_pool_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // command beat packed for the queue
    assign cmd_item.opcode       = i_opcode;
    assign cmd_item.cell_x       = i_cell_x;
    assign cmd_item.cell_y       = i_cell_y;
    assign cmd_item.cell_present = i_cell_present;
    assign cmd_item.kind_index   = i_kind_index;
    assign cmd_item.frame        = i_frame;

    // intake and queue
    aqc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (cmd_item),
        .i_ctrl  (back_ctrl),
        .o_head  (head)
    );

    // store, neighbour reads and result generation
    aqc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_map_width      (r_map_width),
        .i_map_height     (r_map_height),
        .i_tile_size      (r_tile_size),
        .i_pool_count     (r_pool_count),
        .o_ctrl           (back_ctrl),
        .o_valid          (o_valid),
        .o_drawn          (o_drawn),
        .o_quadrant       (o_quadrant),
        .o_pattern_cell   (o_pattern_cell),
        .o_neighbour_mask (o_neighbour_mask),
        .o_src_x          (o_src_x),
        .o_src_y          (o_src_y),
        .o_dest_x         (o_dest_x),
        .o_dest_y         (o_dest_y),
        .o_last           (o_last)
    );

endmodule
